// File: src/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher.
// Used by rc4_csr, rc4_engine and the top level rc4_stream_cipher.
package rc4_pkg;

   localparam int BYTE_W       = 8;
   localparam int KEY_BYTES_DEF = 16;
   localparam int KEY_IDX_W    = 4;
   localparam int KEY_LEN_W    = 5;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_ADDR_W   = 5;

   localparam logic OP_REKEY = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   localparam logic [1:0] REG_KEY_LOW  = 2'd0;
   localparam logic [1:0] REG_KEY_HIGH = 2'd1;
   localparam logic [1:0] REG_KEY_LEN  = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0]    key_byte;
      logic [KEY_LEN_W-1:0] key_len;
   } rc4_key_type;

endpackage

// File: src/rc4_csr.sv
// Configuration registers for the RC4 engine: key words and key length.
// Selects one key byte by index and clamps the key length. Depends on rc4_pkg.
module rc4_csr
   import rc4_pkg::*;
#(
   parameter int KEY_BYTES = KEY_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   input  logic [KEY_IDX_W-1:0]  key_idx,
   output rc4_key_type           key_info
);

   logic [CSR_DATA_W-1:0] key_low_ff, key_low_in;
   logic [CSR_DATA_W-1:0] key_high_ff, key_high_in;
   logic [KEY_LEN_W-1:0]  key_len_ff, key_len_in;
   logic                  wr_en;
   logic [1:0]            reg_sel;
   logic [15:0][BYTE_W-1:0] key_bytes;
   logic [KEY_LEN_W-1:0]  used_len;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[4:3];

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      key_len_in  = key_len_ff;
      csr_prdata  = '0;
      unique case (reg_sel)
         REG_KEY_LOW: begin
            csr_prdata = key_low_ff;
            if (wr_en) key_low_in = csr_pwdata;
         end
         REG_KEY_HIGH: begin
            csr_prdata = key_high_ff;
            if (wr_en) key_high_in = csr_pwdata;
         end
         REG_KEY_LEN: begin
            csr_prdata = {{(CSR_DATA_W-KEY_LEN_W){1'b0}}, key_len_ff};
            if (wr_en) key_len_in = csr_pwdata[KEY_LEN_W-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= KEY_LEN_W'(16);
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         key_len_ff  <= key_len_in;
      end
   end

   always_comb begin
      used_len = key_len_ff;
      if (key_len_ff == '0) used_len = KEY_LEN_W'(1);
      if (key_len_ff > KEY_LEN_W'(KEY_BYTES)) used_len = KEY_LEN_W'(KEY_BYTES);
   end

   assign key_bytes         = {key_high_ff, key_low_ff};
   assign key_info.key_byte = key_bytes[key_idx];
   assign key_info.key_len  = used_len;

endmodule

// File: src/rc4_engine.sv
// RC4 permutation memory with one shared byte adder under a sequencer.
// Runs the key schedule and the keystream generator. Depends on rc4_pkg.
module rc4_engine
   import rc4_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 op,
   input  logic [BYTE_W-1:0]    data_in,
   input  logic                 last_in,
   output logic                 idle,
   input  logic                 out_free,
   output logic                 res_valid,
   output logic [BYTE_W-1:0]    res_data,
   output logic                 res_last,
   output logic [KEY_IDX_W-1:0] key_idx,
   input  rc4_key_type          key_info
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_PJ   = 9'b000000010,
      ST_PSWP = 9'b000000100,
      ST_POUT = 9'b000001000,
      ST_FILL = 9'b000010000,
      ST_KRDA = 9'b000100000,
      ST_KRB  = 9'b001000000,
      ST_KWA  = 9'b010000000,
      ST_KWB  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [BYTE_W-1:0] mem [256];
   logic [BYTE_W-1:0] rd_data_ff;
   logic              wr_en;
   logic [BYTE_W-1:0] wr_addr, wr_data;

   logic [BYTE_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [BYTE_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [BYTE_W-1:0] sx_ff, sx_in, sj_ff, sj_in;
   logic [BYTE_W-1:0] data_ff, data_in_nxt;
   logic              last_ff, last_in_nxt;
   logic              hit_i_ff, hit_i_in, hit_j_ff, hit_j_in;
   logic              byp_ff, byp_in;
   logic [KEY_IDX_W-1:0] kidx_ff, kidx_in, kidx_inc;

   logic [BYTE_W-1:0] opa, opb, opc, sum;
   logic [BYTE_W-1:0] sa, ks;

   assign sum      = opa + opb + opc;
   assign sa       = byp_ff ? sx_ff : rd_data_ff;
   assign kidx_inc = kidx_ff + KEY_IDX_W'(1);
   assign key_idx  = kidx_ff;
   assign idle     = (state_ff == ST_IDLE);
   assign ks       = hit_i_ff ? sj_ff : (hit_j_ff ? sx_ff : rd_data_ff);
   assign res_valid = (state_ff == ST_POUT);
   assign res_data  = data_ff ^ ks;
   assign res_last  = last_ff;

   always_comb begin
      opa = '0;
      opb = '0;
      opc = '0;
      unique case (state_ff)
         ST_IDLE: begin opa = i_ff;  opb = BYTE_W'(1); end
         ST_PJ:   begin opa = j_ff;  opb = rd_data_ff; end
         ST_PSWP: begin opa = sx_ff; opb = rd_data_ff; end
         ST_POUT: begin opa = sx_ff; opb = sj_ff; end
         ST_FILL: begin opa = a_ff;  opb = BYTE_W'(1); end
         ST_KRDA: begin opa = a_ff; end
         ST_KRB:  begin opa = b_ff;  opb = sa; opc = key_info.key_byte; end
         ST_KWA:  begin opa = '0; end
         ST_KWB:  begin opa = a_ff;  opb = BYTE_W'(1); end
         default: begin opa = '0; end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      sx_in       = sx_ff;
      sj_in       = sj_ff;
      data_in_nxt = data_ff;
      last_in_nxt = last_ff;
      hit_i_in    = hit_i_ff;
      hit_j_in    = hit_j_ff;
      byp_in      = byp_ff;
      kidx_in     = kidx_ff;
      wr_en       = 1'b0;
      wr_addr     = a_ff;
      wr_data     = a_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (op == OP_DATA) begin
                  i_in        = sum;
                  data_in_nxt = data_in;
                  last_in_nxt = last_in;
                  state_in    = ST_PJ;
               end else begin
                  a_in     = '0;
                  state_in = ST_FILL;
               end
            end
         end
         ST_PJ: begin
            sx_in    = rd_data_ff;
            j_in     = sum;
            state_in = ST_PSWP;
         end
         ST_PSWP: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff;
            wr_data  = rd_data_ff;
            sj_in    = rd_data_ff;
            hit_i_in = (sum == i_ff);
            hit_j_in = (sum == j_ff);
            state_in = ST_POUT;
         end
         ST_POUT: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = sx_ff;
            if (out_free) state_in = ST_IDLE;
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = a_ff;
            wr_data = a_ff;
            a_in    = sum;
            if (a_ff == '1) begin
               b_in     = '0;
               kidx_in  = '0;
               state_in = ST_KRDA;
            end
         end
         ST_KRDA: begin
            byp_in   = 1'b0;
            state_in = ST_KRB;
         end
         ST_KRB: begin
            sx_in    = sa;
            b_in     = sum;
            state_in = ST_KWA;
         end
         ST_KWA: begin
            wr_en    = 1'b1;
            wr_addr  = a_ff;
            wr_data  = rd_data_ff;
            state_in = ST_KWB;
         end
         ST_KWB: begin
            wr_en   = 1'b1;
            wr_addr = b_ff;
            wr_data = sx_ff;
            byp_in  = (b_ff == sum);
            a_in    = sum;
            if ({1'b0, kidx_ff} + KEY_LEN_W'(1) == key_info.key_len) begin
               kidx_in = '0;
            end else begin
               kidx_in = kidx_inc;
            end
            if (a_ff == '1) begin
               i_in     = '0;
               j_in     = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_KRB;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      sx_ff    <= sx_in;
      sj_ff    <= sj_in;
      data_ff  <= data_in_nxt;
      last_ff  <= last_in_nxt;
      hit_i_ff <= hit_i_in;
      hit_j_ff <= hit_j_in;
      byp_ff   <= byp_in;
      kidx_ff  <= kidx_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[sum];
   end

endmodule

// File: src/rc4_stream_cipher.sv
// RC4 stream cipher engine. A data transaction on the req_ side passes through the
// engine states PJ, PSWP and POUT, waits in POUT until the rsp_ output register is
// free and then lands there; the engine takes no new transaction until it is back
// in idle. A rekey transaction loads the identity permutation, fetches the first
// entry, then runs the key schedule steps (a read and two writes each), keeps the
// engine busy and gives no result. Both kinds are paced by the 256 x 8 permutation
// memory with one read and one write port and by the one shared byte adder. The
// engine takes a new transaction while a finished result still waits on rsp_.
// Data sent before the first rekey returns an undefined keystream.
// Depends on rc4_pkg, rc4_csr and rc4_engine.
module rc4_stream_cipher
   import rc4_pkg::*;
#(
   parameter int KEY_BYTES = KEY_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] data_in
   input  logic                  req_tuser,   // [0] op
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [BYTE_W-1:0]     rsp_tdata,   // [7:0] data_out
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   rc4_key_type          key_info;
   logic [KEY_IDX_W-1:0] key_idx;
   logic                 eng_idle, start, out_free;
   logic                 res_valid, res_last, take;
   logic [BYTE_W-1:0]    res_data;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   rc4_csr #(
      .KEY_BYTES(KEY_BYTES)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .key_idx    (key_idx),
      .key_info   (key_info)
   );

   rc4_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .op       (req_tuser),
      .data_in  (req_tdata),
      .last_in  (req_tlast),
      .idle     (eng_idle),
      .out_free (out_free),
      .res_valid(res_valid),
      .res_data (res_data),
      .res_last (res_last),
      .key_idx  (key_idx),
      .key_info (key_info)
   );

   assign req_tready = eng_idle;
   assign start      = req_tvalid & eng_idle;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign take       = res_valid & out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
         rsp_last_in  = res_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: tb/rc4_stream_cipher_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for rc4_stream_cipher: drives rekey and cipher-byte transactions,
// programs the key registers over APB and checks every output byte against a keystream tracker.
// Depends on rc4_pkg and the rc4_stream_cipher RTL.
module rc4_stream_cipher_test;
   import rc4_pkg::*;

   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam int SETTLE_CYCLES  = 1100;
   localparam int LONG_HOLD      = 400;
   localparam int ITEM_TARGET    = 450;
   localparam int CYCLE_LIMIT    = 750_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;   // [7:0] data_in
   logic                  req_tuser = 1'b0; // [0] op
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [BYTE_W-1:0]     rsp_tdata;        // [7:0] data_out
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } cipher_byte_type;

   class rc4_keystream_tracker;
      logic [CSR_DATA_W-1:0] key_low;
      logic [CSR_DATA_W-1:0] key_high;
      logic [KEY_LEN_W-1:0]  key_length;
      logic [BYTE_W-1:0]     sbox [256];
      logic [BYTE_W-1:0]     idx_i;
      logic [BYTE_W-1:0]     idx_j;
      cipher_byte_type       pending_bytes [$];
      int unsigned           error_count;
      int unsigned           rekey_count;
      int unsigned           byte_count;

      function new();
         key_low = '0;
         key_high = '0;
         key_length = KEY_LEN_W'(KEY_BYTES_DEF);
         foreach (sbox[a]) sbox[a] = '0;
         idx_i = '0;
         idx_j = '0;
         error_count = 0;
         rekey_count = 0;
         byte_count = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_KEY_LOW:  key_low = value;
            REG_KEY_HIGH: key_high = value;
            REG_KEY_LEN:  key_length = value[KEY_LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic op, logic [BYTE_W-1:0] data, logic last);
         int unsigned           n;
         logic [2*CSR_DATA_W-1:0] key_all;
         logic [BYTE_W-1:0]     b;
         logic [BYTE_W-1:0]     t;
         cipher_byte_type       want;
         if (op == OP_REKEY) begin
            n = 32'(key_length);
            if (n < 1) n = 1;
            if (n > KEY_BYTES_DEF) n = KEY_BYTES_DEF;
            key_all = {key_high, key_low};
            for (int a = 0; a < 256; a++) sbox[a] = BYTE_W'(a);
            b = '0;
            for (int a = 0; a < 256; a++) begin
               b = b + sbox[a] + key_all[8*(a % n) +: 8];
               t = sbox[a];
               sbox[a] = sbox[b];
               sbox[b] = t;
            end
            idx_i = '0;
            idx_j = '0;
            rekey_count++;
         end else begin
            idx_i = idx_i + 1'b1;
            idx_j = idx_j + sbox[idx_i];
            t = sbox[idx_i];
            sbox[idx_i] = sbox[idx_j];
            sbox[idx_j] = t;
            t = sbox[idx_i] + sbox[idx_j];
            want.data = data ^ sbox[t];
            want.last = last;
            pending_bytes.push_back(want);
         end
      endfunction

      function void check_response(logic [BYTE_W-1:0] data, logic last);
         cipher_byte_type want;
         if (pending_bytes.size() == 0) begin
            $error("unexpected transaction: data_out %02h, last_out %0b", data, last);
            error_count++;
            return;
         end
         want = pending_bytes.pop_front();
         byte_count++;
         if (data !== want.data) begin
            $error("data_out mismatch: expected %02h, actual %02h", want.data, data);
            error_count++;
         end
         if (last !== want.last) begin
            $error("last_out mismatch: expected %0b, actual %0b", want.last, last);
            error_count++;
         end
      endfunction
   endclass

   rc4_keystream_tracker cipher_tracker;
   int unsigned          items_sent = 0;
   int unsigned          config_writes = 0;
   int unsigned          cycle_count = 0;
   int unsigned          stall_left = 0;
   bit                   no_idle = 1'b0;
   bit                   hold_off_request = 1'b0;

   rc4_stream_cipher dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("timeout with %0d bytes outstanding", cipher_tracker.pending_bytes.size());
         $display("rc4_stream_cipher test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            cipher_tracker.note_request(req_tuser, req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            cipher_tracker.check_response(rsp_tdata, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (hold_off_request) begin
         hold_off_request <= 1'b0;
         stall_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= (stall_left == 0);
      end else if (rsp_tvalid && rsp_tready) begin
         stall_left = no_idle ? 0 : $urandom_range(0, 4);
         rsp_tready <= (stall_left == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(logic op, logic [BYTE_W-1:0] data, logic last);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= data;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic write_register(logic [1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      cipher_tracker.set_register(index, value);
      config_writes++;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (cipher_tracker.pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned          phase;
      int unsigned          msg_len;
      logic [KEY_LEN_W-1:0] len;
      logic                 last;
      cipher_tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset key: sixteen zero bytes
      send_item(OP_REKEY, 8'h00, 1'b0);
      send_item(OP_DATA, 8'h00, 1'b0);
      send_item(OP_DATA, 8'hFF, 1'b1);
      settle();

      // three-byte key "Key", upper key bytes all ones, spare address ignored
      write_register(REG_KEY_LOW, 64'h0000_0000_0079_654B);
      write_register(REG_KEY_HIGH, '1);
      write_register(REG_KEY_LEN, 64'd3);
      write_register(REG_SPARE, '1);
      send_item(OP_REKEY, 8'hFF, 1'b1);
      for (int k = 0; k < 5; k++) send_item(OP_DATA, 8'h00, k == 4);
      settle();

      // zero length acts as one byte
      write_register(REG_KEY_LOW, '1);
      write_register(REG_KEY_LEN, 64'd0);
      send_item(OP_REKEY, 8'h00, 1'b0);
      send_item(OP_DATA, 8'hA5, 1'b0);
      send_item(OP_DATA, 8'h5A, 1'b1);
      settle();

      // length above sixteen saturates
      write_register(REG_KEY_HIGH, 64'h0123_4567_89AB_CDEF);
      write_register(REG_KEY_LEN, 64'd31);
      send_item(OP_REKEY, 8'h00, 1'b0);
      send_item(OP_DATA, 8'h00, 1'b0);
      send_item(OP_DATA, 8'hFF, 1'b1);
      settle();

      // single-byte key, back-to-back rekeys
      write_register(REG_KEY_LEN, 64'd1);
      send_item(OP_REKEY, 8'h00, 1'b0);
      send_item(OP_REKEY, 8'h3C, 1'b1);
      send_item(OP_DATA, 8'hC3, 1'b1);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         no_idle = ($urandom_range(0, 4) == 0);
         msg_len = $urandom_range(1, 20);
         if (phase == 0 || $urandom_range(0, 2) != 0) begin
            settle();
            if ($urandom_range(0, 1))
               write_register(REG_KEY_LOW, {$urandom, $urandom});
            if ($urandom_range(0, 1))
               write_register(REG_KEY_HIGH, {$urandom, $urandom});
            case ($urandom_range(0, 9))
               0:       len = 5'd1;
               1:       len = 5'd16;
               2:       len = 5'd0;
               3:       len = KEY_LEN_W'($urandom_range(17, 31));
               default: len = KEY_LEN_W'($urandom_range(1, 16));
            endcase
            if ($urandom_range(0, 2) != 0 || phase == 0)
               write_register(REG_KEY_LEN, CSR_DATA_W'(len));
            send_item(OP_REKEY, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
         // long run past the index wrap while the receiver holds off
         if (phase == 2) begin
            no_idle = 1'b1;
            msg_len = 270;
            hold_off_request <= 1'b1;
         end
         for (int k = 0; k < msg_len; k++) begin
            if (phase != 2 && $urandom_range(0, 24) == 0)
               send_item(OP_REKEY, BYTE_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            last = (k == msg_len - 1) ? 1'b1 : ($urandom_range(0, 9) == 0);
            send_item(OP_DATA, BYTE_W'($urandom_range(0, 255)), last);
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      while (cipher_tracker.pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d transactions in %0d phases with %0d register writes.",
               items_sent, phase, config_writes);
      $display("Ran %0d key schedules and checked %0d cipher bytes.",
               cipher_tracker.rekey_count, cipher_tracker.byte_count);
      if (cipher_tracker.error_count == 0)
         $display("rc4_stream_cipher test passed");
      else
         $display("rc4_stream_cipher test failed");
      $finish;
   end

endmodule
